// ----- rtl/core/tqr_pkg.sv -----
// Shared types and constants for the ticket queue with removal by ticket.
// Depends on nothing; every module in rtl/core takes its names from here.
`timescale 1ns / 1ps

package tqr_pkg;

    // Queue geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOTAL_W = $clog2(DEPTH * 255 + 1);

    // Field widths fixed by the item formats
    localparam int OP_W        = 2;
    localparam int TICKET_W    = 16;
    localparam int SIZE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int TOTAL_OUT_W = 12;
    localparam int OCC_W       = 5;

    // Saturation limits of the reported totals
    localparam int TOTAL_MAX = 4095;
    localparam int OCC_MAX   = 31;

    localparam logic [TICKET_W-1:0] FIRST_TICKET = 16'd1;

    // Command codes (code 3 behaves as a query)
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SIZE_W-1:0]   group_size;
        logic [TICKET_W-1:0] ticket;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [TICKET_W-1:0]    ticket_out;
        logic [TOTAL_OUT_W-1:0] total_people;
        logic [OCC_W-1:0]       occupancy;
    } rsp_t;

    // One queue slot as stored in memory
    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic [SIZE_W-1:0]   size;
    } entry_t;

    // Request from the controller to the entry memory
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

// ----- rtl/core/ticket_queue_remove_by_id_unit.sv -----
// Top level of the ticket queue with removal by ticket: controller, entry memory, output register.
// Depends on tqr_pkg, tqr_mem and tqr_ctrl.
`timescale 1ns / 1ps

// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one item per command - insert a group,
//   remove a ticket, or query. rsp channel (rsp_valid / rsp_stall / rsp): exactly one
//   result item per command, in command order, carrying status, ticket, total of
//   group sizes and occupancy after the command.
//   Work per command: a query or a rejected command goes straight to its result, an insert into
//   an empty queue writes without a read, other inserts take one read of the tail entry. A remove walks the
//   entry memory one slot a cycle through its single read port, searching and then
//   compacting, over every occupied slot whether or not the ticket is found.
//   One command is in work at a time; the next is accepted the cycle after the
//   previous result moves into the output register.
//   The output register decouples the two sides: while rsp_stall holds a result, the
//   block still accepts and works the next command and then waits with its result
//   until the register frees.
//   Reset (rst_n low, asynchronous) empties the queue and clears totals; memory
//   contents are not cleared, entries beyond the occupancy are never read.

module ticket_queue_remove_by_id_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  tqr_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tqr_pkg::rsp_t rsp
);

    tqr_pkg::mem_req_t mem_req;
    tqr_pkg::entry_t   mem_rdata;
    logic              res_valid;
    logic              res_ready;
    tqr_pkg::rsp_t     res;

    logic              rsp_valid_reg;
    tqr_pkg::rsp_t     rsp_reg;

    tqr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    tqr_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Output register
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (res_ready)
            rsp_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            rsp_reg <= res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks

    // one command at a time: an accepted item blocks the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command accepted while another is in work");

    // a rejected insert reports a full queue and no ticket
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == tqr_pkg::STAT_FULL) |->
        (rsp.ticket_out == 16'd0 &&
         32'(rsp.occupancy) == ((tqr_pkg::DEPTH > tqr_pkg::OCC_MAX) ?
                                tqr_pkg::OCC_MAX : tqr_pkg::DEPTH)))
        else $error("full status with wrong ticket or occupancy");

    // an empty-queue result shows no entries and no people
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == tqr_pkg::STAT_EMPTY) |->
        (rsp.occupancy == '0 && rsp.total_people == '0))
        else $error("empty status with nonzero totals");

    // occupancy never exceeds the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.occupancy) <= tqr_pkg::DEPTH))
        else $error("occupancy above queue depth");

endmodule

// ----- rtl/core/tqr_mem.sv -----
// Entry memory of the ticket queue: one write port, one read port, registered read data.
// Depends on tqr_pkg for the entry and request types.
`timescale 1ns / 1ps

module tqr_mem
(
    input  logic              clk,
    input  tqr_pkg::mem_req_t req,
    output tqr_pkg::entry_t   rdata
);

    tqr_pkg::entry_t entry_mem_reg [tqr_pkg::DEPTH];
    tqr_pkg::entry_t rdata_reg;

    // Write and read in the same cycle; read data is registered and shows up in the next cycle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            entry_mem_reg[req.waddr] <= req.wdata;
        end
        rdata_reg <= entry_mem_reg[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tqr_ctrl.sv -----
// Sequencer of the ticket queue: insert, search and compaction walks over the entry memory,
// plus the occupancy and running total registers. Depends on tqr_pkg.
`timescale 1ns / 1ps

module tqr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  tqr_pkg::cmd_t     cmd,
    output tqr_pkg::mem_req_t mem_req,
    input  tqr_pkg::entry_t   mem_rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output tqr_pkg::rsp_t     res
);

    tqr_pkg::state_t                    state_reg, state_next;
    logic [tqr_pkg::SIZE_W-1:0]         gsize_reg, gsize_next;
    logic [tqr_pkg::TICKET_W-1:0]       want_reg, want_next;
    logic [tqr_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic [tqr_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [tqr_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic [tqr_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [tqr_pkg::TICKET_W-1:0]       tout_reg, tout_next;

    logic [tqr_pkg::IDX_W-1:0]          idx_inc;
    logic                               more;
    logic [tqr_pkg::TICKET_W-1:0]       next_ticket;

    assign idx_inc     = idx_reg + tqr_pkg::IDX_W'(1);
    assign more        = (tqr_pkg::CNT_W'(idx_reg) + tqr_pkg::CNT_W'(1)) < count_reg;
    assign next_ticket = mem_rdata.ticket + tqr_pkg::TICKET_W'(1);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tqr_pkg::S_IDLE;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // Item fields, walk index and pending result
    always_ff @(posedge clk)
    begin
        gsize_reg  <= gsize_next;
        want_reg   <= want_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        tout_reg   <= tout_next;
    end

    // Next state, memory requests
    always_comb
    begin
        state_next    = state_reg;
        gsize_next    = gsize_reg;
        want_next     = want_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        status_next   = status_reg;
        tout_next     = tout_reg;
        mem_req       = '0;
        mem_req.raddr = idx_reg;
        res_valid     = 1'b0;
        cmd_stall     = (state_reg != tqr_pkg::S_IDLE);

        case (state_reg)
            tqr_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    gsize_next  = cmd.group_size;
                    want_next   = cmd.ticket;
                    status_next = tqr_pkg::STAT_OK;
                    tout_next   = '0;
                    state_next  = tqr_pkg::S_DONE;
                    case (cmd.op)
                        tqr_pkg::OP_INSERT:
                        begin
                            if (count_reg == tqr_pkg::CNT_W'(tqr_pkg::DEPTH))
                            begin
                                status_next = tqr_pkg::STAT_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                // empty queue: first ticket, no tail to read
                                mem_req.we           = 1'b1;
                                mem_req.waddr        = '0;
                                mem_req.wdata.ticket = tqr_pkg::FIRST_TICKET;
                                mem_req.wdata.size   = cmd.group_size;
                                count_next = count_reg + tqr_pkg::CNT_W'(1);
                                total_next = total_reg + tqr_pkg::TOTAL_W'(cmd.group_size);
                                tout_next  = tqr_pkg::FIRST_TICKET;
                            end
                            else
                            begin
                                mem_req.raddr = tqr_pkg::IDX_W'(count_reg - tqr_pkg::CNT_W'(1));
                                state_next    = tqr_pkg::S_INS_RD;
                            end
                        end
                        tqr_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = tqr_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                mem_req.raddr = '0;
                                idx_next      = '0;
                                state_next    = tqr_pkg::S_SEARCH;
                            end
                        end
                        default:
                        begin
                            // query and the spare code only report
                        end
                    endcase
                end
            end

            // Tail entry has arrived: append behind it
            tqr_pkg::S_INS_RD:
            begin
                mem_req.we           = 1'b1;
                mem_req.waddr        = tqr_pkg::IDX_W'(count_reg);
                mem_req.wdata.ticket = next_ticket;
                mem_req.wdata.size   = gsize_reg;
                count_next = count_reg + tqr_pkg::CNT_W'(1);
                total_next = total_reg + tqr_pkg::TOTAL_W'(gsize_reg);
                tout_next  = next_ticket;
                state_next = tqr_pkg::S_DONE;
            end

            // Walk from the head, one entry a cycle, for the first match
            tqr_pkg::S_SEARCH:
            begin
                if (mem_rdata.ticket == want_reg)
                begin
                    total_next = total_reg - tqr_pkg::TOTAL_W'(mem_rdata.size);
                    tout_next  = want_reg;
                    if (more)
                    begin
                        mem_req.raddr = idx_inc;
                        idx_next      = idx_inc;
                        state_next    = tqr_pkg::S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - tqr_pkg::CNT_W'(1);
                        state_next = tqr_pkg::S_DONE;
                    end
                end
                else if (more)
                begin
                    mem_req.raddr = idx_inc;
                    idx_next      = idx_inc;
                end
                else
                begin
                    status_next = tqr_pkg::STAT_NOT_FOUND;
                    state_next  = tqr_pkg::S_DONE;
                end
            end

            // Close the gap: entry k+1 moves to k while k+2 is read, so the
            // write never hits the address being read
            tqr_pkg::S_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg - tqr_pkg::IDX_W'(1);
                mem_req.wdata = mem_rdata;
                if (more)
                begin
                    mem_req.raddr = idx_inc;
                    idx_next      = idx_inc;
                end
                else
                begin
                    count_next = count_reg - tqr_pkg::CNT_W'(1);
                    state_next = tqr_pkg::S_DONE;
                end
            end

            // Hand the result to the output register
            tqr_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = tqr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tqr_pkg::S_IDLE;
            end
        endcase
    end

    // Result fields, totals saturated to the reported widths
    always_comb
    begin
        res.status     = status_reg;
        res.ticket_out = tout_reg;
        if (32'(total_reg) > tqr_pkg::TOTAL_MAX)
            res.total_people = tqr_pkg::TOTAL_OUT_W'(tqr_pkg::TOTAL_MAX);
        else
            res.total_people = tqr_pkg::TOTAL_OUT_W'(total_reg);
        if (32'(count_reg) > tqr_pkg::OCC_MAX)
            res.occupancy = tqr_pkg::OCC_W'(tqr_pkg::OCC_MAX);
        else
            res.occupancy = tqr_pkg::OCC_W'(count_reg);
    end

endmodule
